### rtl/wsd_pkg.sv
// Shared constants, tables and types for the wind speed and direction pipeline.
package wsd_pkg;

  localparam int COMP_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD            = 16;
  localparam int ANGLE_W          = 32;
  localparam int SPEED_W          = 16;
  localparam int DIR_W            = 15;
  localparam int DEG_W            = 15;
  localparam int PROD_W           = 64;

  localparam logic [SPEED_W-1:0] SPEED_MAX    = 16'd46341;
  localparam logic [DEG_W-1:0]   DEG_UNITS    = 15'd23040;
  localparam logic [31:0]        GAIN_INV_Q32 = 32'h9B74_EDA8;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF   = 32'h8000_0000;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic vld;
    logic ok;
    logic zero;
  } wsd_tag_t;

endpackage

### rtl/wsd_prep.sv
// Input register stage: sign handling and half-plane fold ahead of the CORDIC chain.
module wsd_prep #(
  parameter int COMP_WIDTH = 16,
  parameter int DATA_W     = 35
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [COMP_WIDTH-1:0]     east_i,
  input  logic signed [COMP_WIDTH-1:0]     north_i,
  input  logic                             east_ok_i,
  input  logic                             north_ok_i,
  output logic signed [DATA_W-1:0]         x_o,
  output logic signed [DATA_W-1:0]         y_o,
  output logic [wsd_pkg::ANGLE_W-1:0]      z_o,
  output wsd_pkg::wsd_tag_t                tag_o
);
  import wsd_pkg::*;

  logic signed [DATA_W-1:0] u_ext;
  logic signed [DATA_W-1:0] v_ext;
  logic signed [DATA_W-1:0] x_d, x_q;
  logic signed [DATA_W-1:0] y_d, y_q;
  logic [ANGLE_W-1:0]       z_d, z_q;
  wsd_tag_t                 tag_d, tag_q;

  assign u_ext = {{(DATA_W-COMP_WIDTH){east_i[COMP_WIDTH-1]}}, east_i};
  assign v_ext = {{(DATA_W-COMP_WIDTH){north_i[COMP_WIDTH-1]}}, north_i};

  // fold into the right half plane: x = |v|, y = u, both negated when v is not positive
  always_comb begin
    if (!north_i[COMP_WIDTH-1] && (north_i != '0)) begin
      x_d = v_ext <<< GUARD;
      y_d = u_ext <<< GUARD;
      z_d = ANGLE_HALF;
    end else begin
      x_d = (-v_ext) <<< GUARD;
      y_d = (-u_ext) <<< GUARD;
      z_d = '0;
    end
    tag_d.vld  = valid_i;
    tag_d.ok   = east_ok_i & north_ok_i;
    tag_d.zero = (east_i == '0) && (north_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign tag_o = tag_q;

endmodule

### rtl/wsd_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module wsd_cordic_stage #(
  parameter int DATA_W = 35,
  parameter int STAGE  = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic signed [DATA_W-1:0]         x_i,
  input  logic signed [DATA_W-1:0]         y_i,
  input  logic [wsd_pkg::ANGLE_W-1:0]      z_i,
  input  wsd_pkg::wsd_tag_t                tag_i,
  output logic signed [DATA_W-1:0]         x_o,
  output logic signed [DATA_W-1:0]         y_o,
  output logic [wsd_pkg::ANGLE_W-1:0]      z_o,
  output wsd_pkg::wsd_tag_t                tag_o
);
  import wsd_pkg::*;

  localparam logic [ANGLE_W-1:0] ATAN_STEP = ATAN_TAB[STAGE];

  logic signed [DATA_W-1:0] xs, ys;
  logic signed [DATA_W-1:0] x_d, x_q;
  logic signed [DATA_W-1:0] y_d, y_q;
  logic [ANGLE_W-1:0]       z_d, z_q;
  wsd_tag_t                 tag_q;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (!y_i[DATA_W-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_STEP;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign tag_o = tag_q;

endmodule

### rtl/wsd_post.sv
// Gain removal, rounding, saturation and angle scaling in two register stages.
module wsd_post #(
  parameter int DATA_W = 35
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic signed [DATA_W-1:0]         x_i,
  input  logic [wsd_pkg::ANGLE_W-1:0]      z_i,
  input  wsd_pkg::wsd_tag_t                tag_i,
  output logic [wsd_pkg::SPEED_W-1:0]      speed_o,
  output logic [wsd_pkg::DIR_W-1:0]        direction_o,
  output logic                             speed_ok_o,
  output logic                             direction_ok_o,
  output logic                             valid_o
);
  import wsd_pkg::*;

  localparam int DPROD_W = ANGLE_W + DEG_W;

  logic [PROD_W-1:0]  mag;
  logic [PROD_W-1:0]  hi_p_d, hi_p_q;
  logic [PROD_W-1:0]  lo_p_d, lo_p_q;
  logic [DPROD_W-1:0] dir_p_d, dir_p_q;
  wsd_tag_t           tag_a_q;

  logic [PROD_W-1:0]        t_sum;
  logic [PROD_W-1:0]        t_rnd;
  logic [PROD_W-GUARD-1:0]  spd_wide;
  logic [DPROD_W:0]         dir_rnd;
  logic [DPROD_W-ANGLE_W:0] dir_wide;
  logic [SPEED_W-1:0]       speed_d, speed_q;
  logic [DIR_W-1:0]         dir_d, dir_q;
  logic                     speed_ok_d, dir_ok_d;
  logic                     speed_ok_q, dir_ok_q, vld_q;

  assign mag     = x_i[DATA_W-1] ? '0 : {{(PROD_W-DATA_W){1'b0}}, x_i};
  assign hi_p_d  = {32'd0, mag[PROD_W-1:32]} * {32'd0, GAIN_INV_Q32};
  assign lo_p_d  = {32'd0, mag[31:0]} * {32'd0, GAIN_INV_Q32};
  assign dir_p_d = DPROD_W'(z_i) * DPROD_W'(DEG_UNITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
    end else if (en_i) begin
      tag_a_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_p_q  <= hi_p_d;
      lo_p_q  <= lo_p_d;
      dir_p_q <= dir_p_d;
    end
  end

  always_comb begin
    t_sum    = hi_p_q + {32'd0, lo_p_q[PROD_W-1:32]};
    t_rnd    = t_sum + (PROD_W'(1) << (GUARD - 1));
    spd_wide = t_rnd[PROD_W-1:GUARD];
    dir_rnd  = {1'b0, dir_p_q} + (DPROD_W+1)'(ANGLE_HALF);
    dir_wide = dir_rnd[DPROD_W:ANGLE_W];

    speed_ok_d = tag_a_q.ok;
    dir_ok_d   = tag_a_q.ok & ~tag_a_q.zero;

    if (!tag_a_q.ok || tag_a_q.zero) begin
      speed_d = '0;
    end else if (spd_wide > (PROD_W-GUARD)'(SPEED_MAX)) begin
      speed_d = SPEED_MAX;
    end else begin
      speed_d = spd_wide[SPEED_W-1:0];
    end

    if (!dir_ok_d || (dir_wide >= (DPROD_W-ANGLE_W+1)'(DEG_UNITS))) begin
      dir_d = '0;
    end else begin
      dir_d = dir_wide[DIR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      speed_ok_q <= 1'b0;
      dir_ok_q   <= 1'b0;
    end else if (en_i) begin
      vld_q      <= tag_a_q.vld;
      speed_ok_q <= speed_ok_d;
      dir_ok_q   <= dir_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      speed_q <= speed_d;
      dir_q   <= dir_d;
    end
  end

  assign speed_o        = speed_q;
  assign direction_o    = dir_q;
  assign speed_ok_o     = speed_ok_q;
  assign direction_ok_o = dir_ok_q;
  assign valid_o        = vld_q;

endmodule

### rtl/wind_speed_direction.sv
// Wind speed and direction from one wind vector through a pipelined CORDIC.
// Stages from accepted word to output word: one input fold stage,
// one stage per CORDIC iteration, two output stages.
// Throughput: one word per cycle; the whole pipeline holds while the output word stalls.
// Reset clears all valid bits; data registers are not reset.
module wind_speed_direction #(
  parameter int COMP_WIDTH   = wsd_pkg::COMP_WIDTH_DEF,
  parameter int CORDIC_STEPS = wsd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COMP_WIDTH-1:0]     east_comp_i,
  input  logic signed [COMP_WIDTH-1:0]     north_comp_i,
  input  logic                             east_ok_i,
  input  logic                             north_ok_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wsd_pkg::SPEED_W-1:0]      speed_o,
  output logic [wsd_pkg::DIR_W-1:0]        direction_o,
  output logic                             speed_ok_o,
  output logic                             direction_ok_o
);
  import wsd_pkg::*;

  localparam int DATA_W = COMP_WIDTH + GUARD + 3;

  logic                     en;
  logic signed [DATA_W-1:0] x_s [CORDIC_STEPS+1];
  logic signed [DATA_W-1:0] y_s [CORDIC_STEPS+1];
  logic [ANGLE_W-1:0]       z_s [CORDIC_STEPS+1];
  wsd_tag_t                 tag_s [CORDIC_STEPS+1];

  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  wsd_prep #(
    .COMP_WIDTH (COMP_WIDTH),
    .DATA_W     (DATA_W)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .east_i     (east_comp_i),
    .north_i    (north_comp_i),
    .east_ok_i  (east_ok_i),
    .north_ok_i (north_ok_i),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .z_o        (z_s[0]),
    .tag_o      (tag_s[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
    wsd_cordic_stage #(
      .DATA_W (DATA_W),
      .STAGE  (g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .tag_i  (tag_s[g]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1]),
      .tag_o  (tag_s[g+1])
    );
  end

  wsd_post #(
    .DATA_W (DATA_W)
  ) u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .x_i            (x_s[CORDIC_STEPS]),
    .z_i            (z_s[CORDIC_STEPS]),
    .tag_i          (tag_s[CORDIC_STEPS]),
    .speed_o        (speed_o),
    .direction_o    (direction_o),
    .speed_ok_o     (speed_ok_o),
    .direction_ok_o (direction_ok_o),
    .valid_o        (out_valid_o)
  );

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_o < DIR_W'(DEG_UNITS)))
    else $error("direction out of range");

  a_bad_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !speed_ok_o) |-> (!direction_ok_o && speed_o == '0 && direction_o == '0))
    else $error("bad input word not cleared");

  a_speed_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speed_o <= SPEED_MAX))
    else $error("speed above saturation limit");

  a_no_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && speed_ok_o && !direction_ok_o) |-> (speed_o == '0 && direction_o == '0))
    else $error("zero vector word not cleared");

endmodule
